// ----- design/web_pkg.sv -----
package web_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_START_TIME   = 3'd0;
  localparam logic [2:0] REG_END_TIME     = 3'd1;
  localparam logic [2:0] REG_START_WEIGHT = 3'd2;
  localparam logic [2:0] REG_END_WEIGHT   = 3'd3;
  localparam logic [2:0] REG_SMOOTHNESS   = 3'd4;

  // What decides the result of a request
  localparam logic [1:0] SEL_RAMP  = 2'd0;
  localparam logic [1:0] SEL_START = 2'd1;
  localparam logic [1:0] SEL_END   = 2'd2;

  // Control that travels alongside every pipeline stage
  typedef struct packed {
    logic       valid;
    logic [1:0] sel;
  } web_ctl_t;

endpackage

// ----- design/web_cfg.sv -----
module web_cfg #(
  parameter int TW     = 32,
  parameter int FB     = 16,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [TW-1:0]     start_time,
  output logic [TW-1:0]     end_time,
  output logic [FB:0]       start_weight,
  output logic [FB:0]       end_weight,
  output logic [FB:0]       smoothness
);
  import web_pkg::*;

  localparam int ASH = (DATA_W > 32) ? 3 : 2;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [2:0]  idx;
  logic        wr;
  logic [FB:0] wval;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:ASH];
  assign wr     = psel && penable && pwrite && pready;

  // Weights keep only the low FB+1 bits of the write data; values above one there are taken as one.
  assign wval = (pwdata[FB:0] > ONE) ? ONE : pwdata[FB:0];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      end_time     <= '0;
      start_weight <= ONE;
      end_weight   <= ONE;
      smoothness   <= '0;
    end else if (wr) begin
      case (idx)
        REG_START_TIME:   start_time   <= pwdata[TW-1:0];
        REG_END_TIME:     end_time     <= pwdata[TW-1:0];
        REG_START_WEIGHT: start_weight <= wval;
        REG_END_WEIGHT:   end_weight   <= wval;
        REG_SMOOTHNESS:   smoothness   <= wval;
        default: ;
      endcase
    end
  end

  // Register reads; times come back sign-extended.
  always_comb begin
    case (idx)
      REG_START_TIME:   prdata = DATA_W'($signed(start_time));
      REG_END_TIME:     prdata = DATA_W'($signed(end_time));
      REG_START_WEIGHT: prdata = DATA_W'(start_weight);
      REG_END_WEIGHT:   prdata = DATA_W'(end_weight);
      REG_SMOOTHNESS:   prdata = DATA_W'(smoothness);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- design/web_div_cell.sv -----
module web_div_cell #(
  parameter int RW = 33,
  parameter int QW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  web_pkg::web_ctl_t ctl_in,
  input  logic [RW-1:0]     r_in,
  input  logic [QW-1:0]     q_in,
  input  logic [RW-1:0]     dv_in,
  output web_pkg::web_ctl_t ctl_out,
  output logic [RW-1:0]     r_out,
  output logic [QW-1:0]     q_out,
  output logic [RW-1:0]     dv_out
);
  import web_pkg::*;

  logic [RW:0]   r2;
  logic [RW:0]   dx;
  logic          ge;
  logic [RW:0]   diff;

  // One restoring step: shift the remainder and try to subtract the divisor.
  assign r2   = {r_in, 1'b0};
  assign dx   = {1'b0, dv_in};
  assign ge   = (r2 >= dx);
  assign diff = r2 - dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out  <= ge ? diff[RW-1:0] : r2[RW-1:0];
      q_out  <= {q_in[QW-2:0], ge};
      dv_out <= dv_in;
    end
  end

endmodule

// ----- design/web_blend.sv -----
module web_blend #(
  parameter int FB = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  web_pkg::web_ctl_t ctl_in,
  input  logic [FB-1:0]     x_in,
  input  logic [FB:0]       start_weight,
  input  logic [FB:0]       end_weight,
  input  logic [FB:0]       smoothness,
  output web_pkg::web_ctl_t ctl_out,
  output logic [FB:0]       weight
);
  import web_pkg::*;

  localparam logic [FB:0] ONE     = {1'b1, {FB{1'b0}}};
  localparam logic [FB:0] LIN_MAX = (FB+1)'(((1 << FB) - 1) / 10000);

  web_ctl_t ctl_a, ctl_b, ctl_c, ctl_d, ctl_e, ctl_f;

  logic          es;
  logic [FB:0]   diff;

  logic [FB-1:0]   a_x;
  logic [2*FB:0]   a_linp;
  logic [2*FB-1:0] a_sq;
  logic [2*FB:0]   linp_c;
  logic [2*FB-1:0] sq_c;

  logic [FB-1:0]   b_x2;
  logic [2*FB-1:0] b_x3p;
  logic [FB:0]     b_lin;
  logic [2*FB-1:0] x3p_c;

  logic [FB:0]     c_h;
  logic [FB:0]     c_lin;
  logic [FB-1:0]   x3_c;
  logic [FB+1:0]   h_raw;

  logic [2*FB+1:0] d_qp;
  logic [FB:0]     d_lin;
  logic [2*FB+1:0] qp_c;

  logic [FB:0]     e_quad;
  logic [FB:0]     e_lin;

  logic [2*FB+1:0] f_mq;
  logic [2*FB+1:0] f_ml;
  logic [FB:0]     f_lin;
  logic [2*FB+1:0] mq_c;
  logic [2*FB+1:0] ml_c;
  logic [FB:0]     m_inv;

  logic [2*FB+2:0] sum_c;
  logic [FB:0]     mix_c;
  logic [FB:0]     w_next;

  // Direction and span of the ramp between the two weights
  assign es   = (end_weight >= start_weight);
  assign diff = es ? (end_weight - start_weight) : (start_weight - end_weight);

  assign linp_c = diff * x_in;
  assign sq_c   = x_in * x_in;
  assign x3p_c  = a_sq[2*FB-1:FB] * a_x;
  assign x3_c   = b_x3p[2*FB-1:FB];
  assign h_raw  = ({2'b00, b_x2} << 1) + {2'b00, b_x2} - ({2'b00, x3_c} << 1);
  assign qp_c   = diff * c_h;
  assign m_inv  = ONE - smoothness;
  assign mq_c   = smoothness * e_quad;
  assign ml_c   = m_inv * e_lin;
  assign sum_c  = {1'b0, f_mq} + {1'b0, f_ml};
  assign mix_c  = sum_c[2*FB:FB];

  // Final selection: held weights, pure linear ramp, or the mix.
  always_comb begin
    case (ctl_f.sel)
      SEL_START: w_next = start_weight;
      SEL_END:   w_next = end_weight;
      SEL_RAMP:  w_next = (smoothness <= LIN_MAX) ? f_lin : mix_c;
      default:   w_next = start_weight;
    endcase
  end

  // Control valid bits of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      ctl_c   <= '0;
      ctl_d   <= '0;
      ctl_e   <= '0;
      ctl_f   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a   <= ctl_in;
      ctl_b   <= ctl_a;
      ctl_c   <= ctl_b;
      ctl_d   <= ctl_c;
      ctl_e   <= ctl_d;
      ctl_f   <= ctl_e;
      ctl_out <= ctl_f;
    end
  end

  // Arithmetic stages, at most one multiplier level each
  always_ff @(posedge clk) begin
    if (en) begin
      // Linear product and x squared
      a_x    <= x_in;
      a_linp <= linp_c;
      a_sq   <= sq_c;
      // Linear ramp and x cubed product
      b_x2   <= a_sq[2*FB-1:FB];
      b_x3p  <= x3p_c;
      b_lin  <= es ? (start_weight + a_linp[2*FB:FB])
                   : (start_weight - a_linp[2*FB:FB]);
      // Smoothstep shape, capped at one
      c_h    <= (h_raw > {1'b0, ONE}) ? ONE : h_raw[FB:0];
      c_lin  <= b_lin;
      // Cubic ramp product
      d_qp   <= qp_c;
      d_lin  <= c_lin;
      // Cubic ramp
      e_quad <= es ? (start_weight + d_qp[2*FB:FB])
                   : (start_weight - d_qp[2*FB:FB]);
      e_lin  <= d_lin;
      // Mix products
      f_mq   <= mq_c;
      f_ml   <= ml_c;
      f_lin  <= e_lin;
      // Output register
      weight <= w_next;
    end
  end

endmodule

// ----- design/weight_envelope_blend_top.sv -----
// Pipeline: one input stage, one divider cell per quotient bit and seven blend
// stages lie between an accepted request and its result.
// Throughput: one request per cycle; the whole pipeline stalls only while the
// output register holds a result that is not taken.
// Reset clears all valid bits and loads the registers with their reset values.
module weight_envelope_blend_top #(
  parameter int TIME_WIDTH       = 32,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // now_time
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]               s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // weight
  output logic [((WEIGHT_FRAC_BITS+8)/8)*8-1:0]         m_tdata,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [((TIME_WIDTH > 32) ? 6 : 5)-1:0]        paddr,
  input  logic [((TIME_WIDTH > 32) ? 64 : 32)-1:0]      pwdata,
  output logic [((TIME_WIDTH > 32) ? 64 : 32)-1:0]      prdata,
  output logic                                          pready
);
  import web_pkg::*;

  localparam int TW     = TIME_WIDTH;
  localparam int FB     = WEIGHT_FRAC_BITS;
  localparam int RW     = TW + 1;
  localparam int OUT_W  = ((FB + 8) / 8) * 8;
  localparam int DATA_W = (TW > 32) ? 64 : 32;
  localparam int ADDR_W = (TW > 32) ? 6 : 5;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [TW-1:0] start_time;
  logic [TW-1:0] end_time;
  logic [FB:0]   start_weight;
  logic [FB:0]   end_weight;
  logic [FB:0]   smoothness;

  logic          adv;
  logic [TW-1:0] now_time;
  logic [1:0]    sel_c;
  logic [RW-1:0] d_c;
  logic [RW-1:0] dv_c;

  web_ctl_t      cell_ctl [0:FB];
  logic [RW-1:0] cell_r   [0:FB];
  logic [FB-1:0] cell_q   [0:FB];
  logic [RW-1:0] cell_dv  [0:FB];

  web_ctl_t      out_ctl;
  logic [FB:0]   weight;

  web_cfg #(
    .TW     (TW),
    .FB     (FB),
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_time   (start_time),
    .end_time     (end_time),
    .start_weight (start_weight),
    .end_weight   (end_weight),
    .smoothness   (smoothness)
  );

  // The pipeline moves whenever the output register is free or being read.
  assign adv      = !out_ctl.valid || m_tready;
  assign s_tready = adv;
  assign now_time = s_tdata[TW-1:0];

  // Input stage: decide the held cases and form the dividend and divisor.
  always_comb begin
    if ($signed(now_time) <= $signed(start_time)) begin
      sel_c = SEL_START;
    end else if ($signed(now_time) >= $signed(end_time)) begin
      sel_c = SEL_END;
    end else begin
      sel_c = SEL_RAMP;
    end
  end

  assign d_c  = {now_time[TW-1], now_time} - {start_time[TW-1], start_time};
  assign dv_c = {end_time[TW-1], end_time} - {start_time[TW-1], start_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_ctl[0] <= '0;
    end else if (adv) begin
      cell_ctl[0].valid <= s_tvalid;
      cell_ctl[0].sel   <= sel_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r[0]  <= d_c;
      cell_q[0]  <= '0;
      cell_dv[0] <= dv_c;
    end
  end

  // Divider row: each cell produces one quotient bit.
  for (genvar k = 0; k < FB; k++) begin : g_cell
    web_div_cell #(
      .RW (RW),
      .QW (FB)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (cell_ctl[k]),
      .r_in    (cell_r[k]),
      .q_in    (cell_q[k]),
      .dv_in   (cell_dv[k]),
      .ctl_out (cell_ctl[k+1]),
      .r_out   (cell_r[k+1]),
      .q_out   (cell_q[k+1]),
      .dv_out  (cell_dv[k+1])
    );
  end

  web_blend #(
    .FB (FB)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .ctl_in       (cell_ctl[FB]),
    .x_in         (cell_q[FB]),
    .start_weight (start_weight),
    .end_weight   (end_weight),
    .smoothness   (smoothness),
    .ctl_out      (out_ctl),
    .weight       (weight)
  );

  assign m_tvalid = out_ctl.valid;
  assign m_tdata  = OUT_W'(weight);

  // The cycle after reset no result is offered.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

  // A blended weight never exceeds one.
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (weight <= ONE))
    else $error("weight above one");

  // A stalled pipeline keeps its pending result.
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> m_tvalid)
    else $error("pending result lost during stall");

endmodule

// ----- bench/weight_envelope_blend_top_test.sv -----
`timescale 1ns / 100ps

module weight_envelope_blend_top_test;

  import web_pkg::*;

  // Fixed-point unit of the weights and the time range of the samples
  localparam int unsigned     WT_ONE      = 65536;
  localparam int              FRAC_BITS   = 16;
  localparam longint          TIME_MAX    = 64'sd2147483647;
  localparam longint          TIME_MIN    = -64'sd2147483648;
  localparam int              IDLE_LIMIT  = 2000;
  localparam int              TAIL_CYCLES = 32;
  localparam int              PHASES      = 12;
  localparam int              PHASE_ITEMS = 100;

  // Register slots that decode to nothing
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  // One line of the directed table: either a register write or a time sample
  typedef struct packed {
    logic        write;
    logic [2:0]  index;
    logic [31:0] value;
    logic        known;
    logic [16:0] weight;
  } plan_row_t;

  // A weight still owed by the block, with the sample that caused it
  typedef struct packed {
    logic [31:0] now;
    logic [16:0] weight;
  } weight_due_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model copy of the register file
  logic signed [31:0] cfg_start_time = '0;
  logic signed [31:0] cfg_end_time   = '0;
  logic [16:0]        cfg_start_wt   = 17'h10000;
  logic [16:0]        cfg_end_wt     = 17'h10000;
  logic [16:0]        cfg_smooth     = '0;

  weight_due_t weights_due[$];
  plan_row_t   plan[$];
  bit          steady       = 1'b0;
  int          stall_left   = 0;
  int          idle_cycles  = 0;
  int          mismatches   = 0;
  int          samples_sent = 0;
  int          ramp_hits    = 0;
  int          reg_writes   = 0;

  weight_envelope_blend_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Weight register values keep 17 bits and never exceed one
  function automatic logic [16:0] cap_to_one(input logic [31:0] value);
    return (value[16:0] > WT_ONE) ? 17'h10000 : value[16:0];
  endfunction

  // Move from s towards e by the fraction f
  function automatic longint unsigned weight_ramp(input longint unsigned s,
                                                  input longint unsigned e,
                                                  input longint unsigned f);
    if (e >= s) begin
      return s + (((e - s) * f) >> FRAC_BITS);
    end
    return s - (((s - e) * f) >> FRAC_BITS);
  endfunction

  // Expected weight for one time sample under the current registers
  function automatic logic [16:0] blend_weight(input logic [31:0] sample);
    longint t, st, et;
    longint unsigned s, e, m, rem, span, x, lin, x2, x3, h, quad, mixed;
    t  = longint'($signed(sample));
    st = cfg_start_time;
    et = cfg_end_time;
    s  = cfg_start_wt;
    e  = cfg_end_wt;
    m  = cfg_smooth;
    if (t <= st) begin
      return s[16:0];
    end
    if (t >= et) begin
      return e[16:0];
    end
    // Restoring division gives the position inside the ramp
    rem  = t - st;
    span = et - st;
    x    = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      x   = x << 1;
      if (rem >= span) begin
        rem = rem - span;
        x   = x | 1;
      end
    end
    lin = weight_ramp(s, e, x);
    // Smoothness under one ten-thousandth leaves the ramp linear
    if (m * 10000 < WT_ONE) begin
      return lin[16:0];
    end
    x2 = (x * x) >> FRAC_BITS;
    x3 = (x2 * x) >> FRAC_BITS;
    h  = 3 * x2 - 2 * x3;
    if (h > WT_ONE) begin
      h = WT_ONE;
    end
    quad  = weight_ramp(s, e, h);
    mixed = (m * quad + (WT_ONE - m) * lin) >> FRAC_BITS;
    return mixed[16:0];
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] index, input logic [31:0] value);
    plan_row_t row;
    row        = '0;
    row.write  = 1'b1;
    row.index  = index;
    row.value  = value;
    return row;
  endfunction

  function automatic plan_row_t time_row(input logic [31:0] value, input logic known,
                                         input logic [16:0] weight);
    plan_row_t row;
    row        = '0;
    row.value  = value;
    row.known  = known;
    row.weight = weight;
    return row;
  endfunction

  // Weights for the random settings, with the edges and raw bus values favoured
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return WT_ONE;
      2: return $urandom;
      3: return $urandom_range(0, 16);
      default: return $urandom_range(0, WT_ONE);
    endcase
  endfunction

  task automatic report_mismatch(input string line);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH %s", line);
    end
  endtask

  // Send one time sample and record the weight it must produce
  task automatic send_sample(input logic [31:0] sample, input logic known,
                             input logic [16:0] typed);
    int          gap;
    weight_due_t due;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    due.now    = sample;
    due.weight = known ? typed : blend_weight(sample);
    weights_due.push_back(due);
    samples_sent++;
    if ($signed(sample) > cfg_start_time && $signed(sample) < cfg_end_time) begin
      ramp_hits++;
    end
  endtask

  // Hold off new requests until every owed weight has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk);
  endtask

  // Setup and access cycle; the bus stays selected until released
  task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_START_TIME:   cfg_start_time = value;
      REG_END_TIME:     cfg_end_time   = value;
      REG_START_WEIGHT: cfg_start_wt   = cap_to_one(value);
      REG_END_WEIGHT:   cfg_end_wt     = cap_to_one(value);
      REG_SMOOTHNESS:   cfg_smooth     = cap_to_one(value);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls per request, checked in order
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (weights_due.size() == 0) begin
          report_mismatch($sformatf("weight %0d arrived with nothing outstanding",
                                    m_tdata));
        end else if (m_tdata !== {7'd0, weights_due[0].weight}) begin
          report_mismatch($sformatf("time %h: weight %0d, expected %0d",
                                    weights_due[0].now, m_tdata, weights_due[0].weight));
          void'(weights_due.pop_front());
        end else begin
          void'(weights_due.pop_front());
        end
        stall_left = steady ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles in which no request of any kind completes
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bit          bus_held;
    longint      st, et, span;
    longint      pos;
    logic [31:0] sample;
    int          pick;

    // Directed table: after-reset values, end points, both ramp shapes,
    // the linear threshold, capped and masked weights, start not before end
    // and writes to unused register slots
    plan.push_back(time_row(32'h0000_0000, 1'b1, 17'h10000));
    plan.push_back(time_row(32'h8000_0000, 1'b1, 17'h10000));
    plan.push_back(time_row(32'h7FFF_FFFF, 1'b1, 17'h10000));
    plan.push_back(reg_row(REG_START_WEIGHT, 32'h0000_0000));
    plan.push_back(reg_row(REG_END_WEIGHT, 32'h0001_0000));
    plan.push_back(reg_row(REG_END_TIME, 32'h0001_0000));
    plan.push_back(time_row(32'h0000_0000, 1'b1, 17'd0));
    plan.push_back(time_row(32'h0001_0000, 1'b1, 17'h10000));
    plan.push_back(time_row(32'h0000_8000, 1'b1, 17'd32768));
    plan.push_back(time_row(32'h0000_0001, 1'b1, 17'd1));
    plan.push_back(time_row(32'h0000_FFFF, 1'b1, 17'd65535));
    plan.push_back(reg_row(REG_SMOOTHNESS, 32'h0001_FFFF));
    plan.push_back(time_row(32'h0000_8000, 1'b1, 17'd32768));
    plan.push_back(time_row(32'h0000_4000, 1'b1, 17'd10240));
    plan.push_back(reg_row(REG_SMOOTHNESS, 32'd6));
    plan.push_back(time_row(32'h0000_4000, 1'b1, 17'd16384));
    plan.push_back(reg_row(REG_SMOOTHNESS, 32'd7));
    plan.push_back(time_row(32'h0000_4000, 1'b0, 17'd0));
    plan.push_back(reg_row(REG_START_WEIGHT, 32'h0003_FFFF));
    plan.push_back(reg_row(REG_END_WEIGHT, 32'h0002_0000));
    plan.push_back(reg_row(REG_SMOOTHNESS, 32'h0000_8000));
    plan.push_back(time_row(32'h0000_4000, 1'b0, 17'd0));
    plan.push_back(time_row(32'h0000_C000, 1'b0, 17'd0));
    plan.push_back(reg_row(REG_START_TIME, 32'h8000_0000));
    plan.push_back(reg_row(REG_END_TIME, 32'h7FFF_FFFF));
    plan.push_back(time_row(32'h0000_0000, 1'b0, 17'd0));
    plan.push_back(time_row(32'h8000_0001, 1'b0, 17'd0));
    plan.push_back(time_row(32'h7FFF_FFFE, 1'b0, 17'd0));
    plan.push_back(time_row(32'h8000_0000, 1'b1, 17'h10000));
    plan.push_back(time_row(32'h7FFF_FFFF, 1'b1, 17'd0));
    plan.push_back(reg_row(REG_START_TIME, 32'd5));
    plan.push_back(reg_row(REG_END_TIME, 32'hFFFF_FFFB));
    plan.push_back(time_row(32'd5, 1'b1, 17'h10000));
    plan.push_back(time_row(32'd6, 1'b1, 17'd0));
    plan.push_back(time_row(32'hFFFF_FFF6, 1'b1, 17'h10000));
    plan.push_back(reg_row(REG_SPARE_FIRST, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_SPARE_LAST, 32'h0000_0000));
    plan.push_back(time_row(32'd6, 1'b1, 17'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; writes wait for the pipeline to empty
    bus_held = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].write) begin
        if (!bus_held) begin
          wait_drained();
        end
        reg_write(plan[i].index, plan[i].value);
        bus_held = 1'b1;
      end else begin
        if (bus_held) begin
          release_bus();
        end
        bus_held = 1'b0;
        send_sample(plan[i].value, plan[i].known, plan[i].weight);
      end
    end

    // Random phases: a fresh setting, then samples mostly inside the ramp
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      steady = (phase % 4 == 3);
      st     = longint'($signed($urandom));
      pick   = $urandom_range(0, 9);
      if (pick <= 2) begin
        span = $urandom_range(1, 64);
      end else if (pick <= 5) begin
        span = $urandom_range(65, 1 << 20);
      end else if (pick <= 7) begin
        span = longint'($urandom);
        if (span == 0) begin
          span = 1;
        end
      end else begin
        span = -longint'($urandom_range(0, 1000));
      end
      if (st + span > TIME_MAX) begin
        st = TIME_MAX - span;
      end
      if (st + span < TIME_MIN) begin
        st = TIME_MIN - span;
      end
      et = st + span;
      reg_write(REG_START_TIME, st[31:0]);
      reg_write(REG_END_TIME, et[31:0]);
      reg_write(REG_START_WEIGHT, pick_weight());
      reg_write(REG_END_WEIGHT, pick_weight());
      reg_write(REG_SMOOTHNESS, pick_weight());
      if (phase % 4 == 1) begin
        reg_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
      end
      release_bus();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14 && et > st) begin
          pos = st + longint'({$urandom, $urandom} % (et - st + 1));
        end else if (pick < 17) begin
          pos = ((pick == 14) ? st : et) + $urandom_range(0, 4) - 2;
        end else begin
          pos = longint'($signed($urandom));
        end
        sample = pos[31:0];
        send_sample(sample, 1'b0, 17'd0);
      end
    end

    // Let the last weights come back, then a short quiet tail
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d time samples under %0d register writes,",
             samples_sent, reg_writes);
    $display("%0d of them strictly inside a ramp; %0d mismatches.", ramp_hits, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
